// ----- design/tstp_pkg.sv -----
package tstp_pkg;

  localparam int CHAR_W = 8;
  localparam int BPB_W  = 6;
  localparam int TPB_W  = 15;
  localparam int MULT_W = BPB_W + TPB_W;
  localparam int VAL_W  = 64;
  localparam int CNT_W  = $clog2(MULT_W);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TPB_W;

  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CH_BAR  = 8'h42;
  localparam logic [CHAR_W-1:0] CH_BEAT = 8'h62;
  localparam logic [CHAR_W-1:0] CH_TICK = 8'h74;

  localparam logic [MULT_W-1:0] DEC_BASE = MULT_W'(10);

  localparam logic [BPB_W-1:0] BPB_RESET = BPB_W'(4);
  localparam logic [TPB_W-1:0] TPB_RESET = TPB_W'(96);

  localparam logic [CFG_IDX_W-1:0] CFG_BPB = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TPB = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FORMAT   = 3'd1,
    ST_ORDER    = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_ZERO_CFG = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    UNIT_BAR  = 2'd0,
    UNIT_BEAT = 2'd1,
    UNIT_TICK = 2'd2,
    UNIT_NONE = 2'd3
  } unit_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } mac_status_t;

endpackage

// ----- design/tstp_if.sv -----
interface tstp_in_if import tstp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

interface tstp_out_if import tstp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] ticks;
  status_t          status;

  modport source (output valid, output ticks, output status, input ready);
  modport sink (input valid, input ticks, input status, output ready);
endinterface

interface tstp_cfg_if import tstp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/tstp_mac.sv -----
module tstp_mac import tstp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [VAL_W-1:0]  num,
  input  logic [MULT_W-1:0] mult,
  input  logic [VAL_W-1:0]  addend,
  output logic [VAL_W-1:0]  sum,
  output mac_status_t       status
);

  logic [VAL_W-1:0]  acc;
  logic [MULT_W-1:0] mshift;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              adding;
  logic              ovf;
  logic              done;

  logic [VAL_W-1:0] part;
  logic [VAL_W:0]   step;
  logic [VAL_W:0]   fin;

  always_comb begin
    part = mshift[MULT_W-1] ? num : '0;
    step = {1'b0, acc[VAL_W-2:0], 1'b0} + {1'b0, part};
    fin  = {1'b0, acc} + {1'b0, addend};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      adding <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc    <= '0;
        mshift <= mult;
        cnt    <= CNT_W'(MULT_W - 1);
        ovf    <= 1'b0;
        busy   <= 1'b1;
        adding <= 1'b0;
      end else if (busy && !adding) begin
        acc    <= step[VAL_W-1:0];
        ovf    <= ovf | acc[VAL_W-1] | step[VAL_W];
        mshift <= {mshift[MULT_W-2:0], 1'b0};
        if (cnt == '0) begin
          adding <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end else if (adding) begin
        sum    <= fin[VAL_W-1:0];
        ovf    <= ovf | fin[VAL_W];
        adding <= 1'b0;
        busy   <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign status.ovf  = ovf;

endmodule

// ----- design/time_string_to_ticks_parser_unit.sv -----
// Musical time string parser (B bars, b beats, t ticks, e.g. "2B3b10t").
// item:   one character per word, last marks the end of the string.
// result: one word per string, carrying total ticks and status, raised
//         from the finish step once a word marked last is through and the
//         output register is free; other characters give no result.
// cfg:    writes the bar length in beats (index 0) and ticks_per_beat
//         (index 1); always ready, write only while the parser is idle.
// Timing: a digit or a well placed unit letter goes from acceptance through
//         the shared serial multiply-add unit before the next word can be
//         taken: one multiplier bit per cycle over a 21-bit multiplier,
//         then one 64-bit add, a commit step in the run state and a finish
//         step. Any other character (bad character, misplaced unit letter,
//         or any character after an error) goes straight to the finish step.
// Reset:  clears the parse state and the result valid flag; registers return
//         to 4 beats per bar and 96 ticks per beat.
// Stall:  a finished result waits in the output register; the next string
//         is parsed meanwhile, and only its own final word waits for the
//         output register to drain.
module time_string_to_ticks_parser_unit import tstp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tstp_in_if.sink    item,
  tstp_out_if.source result,
  tstp_cfg_if.sink   cfg
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_RUN    = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t            state;
  logic [BPB_W-1:0]  bar_beats;
  logic [TPB_W-1:0]  ticks_per_beat;
  logic [VAL_W-1:0]  number_acc;
  logic [VAL_W-1:0]  total_acc;
  unit_t             prev_unit;
  logic              expect_digit;
  logic              first_char;
  logic              lone_zero;
  status_t           error_code;
  logic              last_q;
  logic              op_digit;
  logic [3:0]        digit;

  logic              accept;
  logic              is_digit;
  unit_t             unit;
  logic              order_bad;
  logic              mac_start;
  logic [MULT_W-1:0] mult;
  logic [VAL_W-1:0]  addend;
  logic [VAL_W-1:0]  mac_sum;
  mac_status_t       mac_st;
  logic              out_free;
  logic              parse_clear;
  status_t           final_status;

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign accept     = item.valid && item.ready;

  always_comb begin
    is_digit = (item.character >= CH_ZERO) && (item.character <= CH_NINE);
    unique case (item.character)
      CH_BAR:  unit = UNIT_BAR;
      CH_BEAT: unit = UNIT_BEAT;
      CH_TICK: unit = UNIT_TICK;
      default: unit = UNIT_NONE;
    endcase
    order_bad = (prev_unit != UNIT_NONE) && (unit <= prev_unit);
    mac_start = accept && (error_code == ST_OK) &&
                (is_digit || (unit != UNIT_NONE && !expect_digit && !order_bad));
    case (unit)
      UNIT_BAR:  mult = MULT_W'(bar_beats) * MULT_W'(ticks_per_beat);
      UNIT_BEAT: mult = MULT_W'(ticks_per_beat);
      UNIT_TICK: mult = MULT_W'(1);
      default:   mult = DEC_BASE;
    endcase
    if (is_digit) begin
      mult = DEC_BASE;
    end
    addend = op_digit ? VAL_W'(digit) : total_acc;
  end

  always_comb begin
    if (bar_beats == '0 || ticks_per_beat == '0) begin
      final_status = ST_ZERO_CFG;
    end else if (lone_zero) begin
      final_status = ST_OK;
    end else if (error_code != ST_OK) begin
      final_status = error_code;
    end else if (!expect_digit) begin
      final_status = ST_FORMAT;
    end else begin
      final_status = ST_OK;
    end
    out_free    = !result.valid || result.ready;
    parse_clear = (state == S_FINISH) && last_q && out_free;
  end

  tstp_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .start  (mac_start),
    .num    (number_acc),
    .mult   (mult),
    .addend (addend),
    .sum    (mac_sum),
    .status (mac_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      bar_beats      <= BPB_RESET;
      ticks_per_beat <= TPB_RESET;
      number_acc     <= '0;
      total_acc      <= '0;
      prev_unit      <= UNIT_NONE;
      expect_digit   <= 1'b1;
      first_char     <= 1'b1;
      lone_zero      <= 1'b0;
      error_code     <= ST_OK;
      result.valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          CFG_BPB: bar_beats      <= cfg.data[BPB_W-1:0];
          CFG_TPB: ticks_per_beat <= cfg.data[TPB_W-1:0];
          default: ;
        endcase
      end

      if (result.valid && result.ready && !parse_clear) begin
        result.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            lone_zero  <= first_char && (item.character == CH_ZERO);
            first_char <= 1'b0;
            last_q     <= item.last;
            op_digit   <= is_digit;
            digit      <= item.character[3:0];
            if (error_code == ST_OK && !is_digit) begin
              if (unit == UNIT_NONE || expect_digit) begin
                error_code <= ST_FORMAT;
              end else if (order_bad) begin
                error_code <= ST_ORDER;
              end else begin
                prev_unit <= unit;
              end
            end
            state <= mac_start ? S_RUN : S_FINISH;
          end
        end
        S_RUN: begin
          if (mac_st.done) begin
            if (mac_st.ovf) begin
              error_code <= ST_OVERFLOW;
            end else if (op_digit) begin
              number_acc   <= mac_sum;
              expect_digit <= 1'b0;
            end else begin
              total_acc    <= mac_sum;
              number_acc   <= '0;
              expect_digit <= 1'b1;
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!last_q) begin
            state <= S_IDLE;
          end else if (out_free) begin
            result.valid  <= 1'b1;
            result.status <= final_status;
            result.ticks  <= (final_status == ST_OK && !lone_zero) ? total_acc : '0;
            number_acc    <= '0;
            total_acc     <= '0;
            prev_unit     <= UNIT_NONE;
            expect_digit  <= 1'b1;
            first_char    <= 1'b1;
            lone_zero     <= 1'b0;
            error_code    <= ST_OK;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    mac_st.busy |-> !item.ready)
    else $error("item accepted while multiply-add busy");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    mac_st.done |-> (state == S_RUN))
    else $error("multiply-add done outside run state");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (error_code != ST_OK && !parse_clear) |=> $stable(error_code))
    else $error("error code changed before end of string");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == S_FINISH))
    else $error("result raised outside finish state");

endmodule

// ----- verif/time_string_to_ticks_parser_unit_checker.sv -----
module time_string_to_ticks_parser_unit_checker import tstp_pkg::*; (
  input  logic clk,
  input  logic rst,
  tstp_in_if   item,
  tstp_out_if  result,
  tstp_cfg_if  cfg,
  output int   mismatches,
  output int   awaited,
  output int   strings_checked,
  output int   strings_rejected
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VAL_W-1:0] ticks;
    status_t          status;
  } tick_total_t;

  tick_total_t        totals_due[$];
  tick_total_t        due;
  logic [BPB_W-1:0]   bar_beats;
  logic [TPB_W-1:0]   beat_ticks;
  logic [VAL_W-1:0]   group_val;
  logic [VAL_W-1:0]   tick_sum;
  unit_t              last_unit;
  unit_t              this_unit;
  logic               need_digit;
  logic               at_start;
  logic               only_zero;
  logic               is_unit;
  status_t            first_err;
  status_t            verdict;
  logic [MULT_W-1:0]  scale;
  logic [VAL_W+3:0]   shifted;
  logic [2*VAL_W-1:0] product;
  logic [VAL_W:0]     sum;
  int                 err_n = 0;
  int                 n_checked = 0;
  int                 n_rejected = 0;

  task automatic clear_parse();
    group_val  = '0;
    tick_sum   = '0;
    last_unit  = UNIT_NONE;
    need_digit = 1'b1;
    at_start   = 1'b1;
    only_zero  = 1'b0;
    first_err  = ST_OK;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      totals_due.delete();
      bar_beats  = BPB_RESET;
      beat_ticks = TPB_RESET;
      clear_parse();
    end else begin
      if (result.valid && result.ready) begin
        if (totals_due.size() == 0) begin
          err_n++;
          if (err_n <= 10)
            $display("%0t: result with no string pending: ticks=%0d status=%0d",
                     $time, result.ticks, result.status);
        end else begin
          due = totals_due.pop_front();
          n_checked++;
          if (result.ticks !== due.ticks || result.status !== due.status) begin
            err_n++;
            if (err_n <= 10)
              $display("%0t: mismatch: ticks=%0d status=%0d, expected ticks=%0d status=%0d",
                       $time, result.ticks, result.status, due.ticks, due.status);
          end
        end
      end

      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_BPB) bar_beats = cfg.data[BPB_W-1:0];
        else if (cfg.index == CFG_TPB) beat_ticks = cfg.data[TPB_W-1:0];
      end

      if (item.valid && item.ready) begin
        only_zero = at_start && item.character == CH_ZERO;
        at_start  = 1'b0;
        if (first_err == ST_OK) begin
          is_unit   = 1'b1;
          this_unit = UNIT_NONE;
          case (item.character)
            CH_BAR:  this_unit = UNIT_BAR;
            CH_BEAT: this_unit = UNIT_BEAT;
            CH_TICK: this_unit = UNIT_TICK;
            default: is_unit = 1'b0;
          endcase
          if (item.character >= CH_ZERO && item.character <= CH_NINE) begin
            shifted = {4'b0, group_val} * 4'd10 + item.character - CH_ZERO;
            if (shifted[VAL_W+3:VAL_W] != 0) first_err = ST_OVERFLOW;
            else begin
              group_val  = shifted[VAL_W-1:0];
              need_digit = 1'b0;
            end
          end else if (!is_unit || need_digit) begin
            first_err = ST_FORMAT;
          end else if (last_unit != UNIT_NONE && this_unit <= last_unit) begin
            first_err = ST_ORDER;
          end else begin
            last_unit = this_unit;
            case (this_unit)
              UNIT_BAR:  scale = bar_beats * beat_ticks;
              UNIT_BEAT: scale = beat_ticks;
              default:   scale = MULT_W'(1);
            endcase
            product = group_val * scale;
            sum     = tick_sum + product[VAL_W-1:0];
            if (product[2*VAL_W-1:VAL_W] != 0 || sum[VAL_W]) first_err = ST_OVERFLOW;
            else begin
              tick_sum   = sum[VAL_W-1:0];
              group_val  = '0;
              need_digit = 1'b1;
            end
          end
        end

        if (item.last) begin
          if (bar_beats == 0 || beat_ticks == 0) verdict = ST_ZERO_CFG;
          else if (only_zero) verdict = ST_OK;
          else if (first_err != ST_OK) verdict = first_err;
          else if (!need_digit) verdict = ST_FORMAT;
          else verdict = ST_OK;
          due.status = verdict;
          due.ticks  = (verdict == ST_OK && !only_zero) ? tick_sum : '0;
          totals_due.push_back(due);
          if (verdict != ST_OK) n_rejected++;
          clear_parse();
        end
      end
    end
    mismatches       <= err_n;
    awaited          <= totals_due.size();
    strings_checked  <= n_checked;
    strings_rejected <= n_rejected;
  end

endmodule

// ----- verif/time_string_to_ticks_parser_unit_tb.sv -----
module time_string_to_ticks_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tstp_pkg::*;

  localparam int SETTLE    = 40;
  localparam int LONG_HOLD = 600;

  logic clk;
  logic rst;

  tstp_in_if  item();
  tstp_out_if result();
  tstp_cfg_if cfg();

  int mismatches;
  int awaited;
  int strings_checked;
  int strings_rejected;
  int src_idle_pct = 24;
  int snk_idle_pct = 78;
  int holds_asked = 0;
  int holds_done = 0;
  int chars_sent = 0;
  int settings = 0;

  logic [CHAR_W-1:0] text[$];

  time_string_to_ticks_parser_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg)
  );

  time_string_to_ticks_parser_unit_checker u_chk (
    .clk              (clk),
    .rst              (rst),
    .item             (item),
    .result           (result),
    .cfg              (cfg),
    .mismatches       (mismatches),
    .awaited          (awaited),
    .strings_checked  (strings_checked),
    .strings_rejected (strings_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still outstanding", awaited);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        result.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        result.ready <= $urandom_range(99) >= snk_idle_pct;
      end
    end
  end

  function automatic logic [CHAR_W-1:0] unit_letter(input int u);
    case (u)
      0:       return CH_BAR;
      1:       return CH_BEAT;
      default: return CH_TICK;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char();
    return CH_ZERO + CHAR_W'($urandom_range(9));
  endfunction

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endtask

  task automatic add_number();
    int pick;
    int ndig;
    pick = $urandom_range(99);
    if (pick < 80) ndig = $urandom_range(1, 3);
    else if (pick < 94) ndig = $urandom_range(4, 12);
    else ndig = $urandom_range(17, 20);
    repeat (ndig) text.push_back(digit_char());
  endtask

  task automatic send_text();
    for (int i = 0; i < text.size(); i++) begin
      if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
        item.valid <= 1'b0;
        @(posedge clk);
        while ($urandom_range(99) < src_idle_pct) @(posedge clk);
      end
      item.valid     <= 1'b1;
      item.character <= text[i];
      item.last      <= (i == text.size() - 1);
      do @(posedge clk); while (!item.ready);
      chars_sent++;
    end
  endtask

  task automatic say(input string s);
    text.delete();
    append_text(s);
    send_text();
  endtask

  task automatic run_random(input int count);
    int stop;
    int pick;
    int mask;
    stop = chars_sent + count;
    while (chars_sent < stop) begin
      text.delete();
      pick = $urandom_range(99);
      if (pick < 5) begin
        text.push_back(CH_ZERO);
      end else if (pick < 78) begin
        mask = $urandom_range(1, 7);
        for (int u = 0; u < 3; u++) begin
          if (mask[u]) begin
            add_number();
            text.push_back(unit_letter(u));
          end
        end
        if (pick >= 70) add_number();
        else if ($urandom_range(99) < 8)
          text[$urandom_range(text.size() - 1)] = CHAR_W'($urandom_range(255));
      end else if (pick < 85) begin
        repeat ($urandom_range(2, 3)) begin
          add_number();
          text.push_back(unit_letter($urandom_range(2)));
        end
      end else if (pick < 90) begin
        text.push_back(unit_letter($urandom_range(2)));
        if ($urandom_range(1)) begin
          add_number();
          text.push_back(CH_TICK);
        end
      end else if (pick < 93) begin
        // push the total right up against the 64-bit ceiling
        append_text("1b18446744073709551");
        repeat (3) text.push_back(digit_char());
        text.push_back(CH_TICK);
      end else begin
        repeat ($urandom_range(1, 6)) text.push_back(CHAR_W'($urandom_range(255)));
      end
      send_text();
    end
  endtask

  task automatic drain();
    item.valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(input logic [BPB_W-1:0] bpb, input logic [TPB_W-1:0] tpb);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom);
    word[BPB_W-1:0] = bpb;
    cfg.valid <= 1'b1;
    cfg.index <= CFG_BPB;
    cfg.data  <= word;
    do @(posedge clk); while (!cfg.ready);
    cfg.index <= CFG_TPB;
    cfg.data  <= tpb;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    settings++;
  endtask

  initial begin
    rst            <= 1'b1;
    item.valid     <= 1'b0;
    item.character <= '0;
    item.last      <= 1'b0;
    cfg.valid      <= 1'b0;
    cfg.index      <= CFG_BPB;
    cfg.data       <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    say("0");
    say("2B3b10t");
    say("B");
    say("5");
    say("00");
    say("1b1B");
    say("7t7t");
    text = {8'h00};
    send_text();
    text = {8'hff};
    send_text();

    drain();
    set_regs(BPB_W'(32), TPB_W'(32767));
    run_random(200);

    drain();
    src_idle_pct = 78;
    snk_idle_pct <= 24;
    set_regs(BPB_W'(63), TPB_W'(1));
    run_random(200);

    drain();
    src_idle_pct = 0;
    snk_idle_pct <= 0;
    set_regs(BPB_W'(0), TPB_W'(96));
    run_random(40);

    drain();
    set_regs(BPB_W'(7), TPB_W'(0));
    run_random(40);

    drain();
    set_regs(BPB_W'($urandom_range(1, 32)), TPB_W'($urandom_range(1, 32767)));
    // hold off the result side while characters keep coming
    holds_asked <= holds_asked + 1;
    run_random(170);

    drain();
    $display("Sent %0d characters under reset defaults and %0d register settings;",
             chars_sent, settings);
    $display("checked %0d strings, %0d of them ending with an error status.",
             strings_checked, strings_rejected);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
